// File: rtl/core/scl_pkg.sv
// constants, codes and result type for the serial command link
// no dependencies; used by serial_command_link_fsm
`default_nettype none

package scl_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);

  localparam int KEY_LEN      = 5;
  localparam int KP_W         = 3;
  localparam int NUM_WORDS    = 5;
  localparam int LONGEST_WORD = 13;
  localparam int WPOS_W       = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SKIP  = 8'hff;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{CH_QUOTE, "c", "m", "d", CH_QUOTE};

  // candidate order is match priority
  localparam logic [7:0] WORD_TEXT [NUM_WORDS][LONGEST_WORD] = '{
    '{"c", "o", "n", "n", "e", "c", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"s", "t", "a", "r", "t", "_", "p", "r", "e", "d", "i", "c", "t"},
    '{"s", "t", "a", "r", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL,
      CH_NUL},
    '{"s", "t", "o", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL,
      CH_NUL},
    '{"d", "i", "s", "c", "o", "n", "n", "e", "c", "t", CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [WPOS_W-1:0] WORD_LEN [NUM_WORDS] = '{4'd7, 4'd13, 4'd5, 4'd4, 4'd10};

  // command codes
  localparam logic [2:0] CODE_NONE   = 3'd0;
  localparam logic [2:0] CODE_LINK   = 3'd1;
  localparam logic [2:0] CODE_STREAM = 3'd2;
  localparam logic [2:0] CODE_INFER  = 3'd3;
  localparam logic [2:0] CODE_HALT   = 3'd4;
  localparam logic [2:0] CODE_UNLINK = 3'd5;

  localparam logic [2:0] WORD_CODE [NUM_WORDS] = '{
    CODE_LINK, CODE_INFER, CODE_STREAM, CODE_HALT, CODE_UNLINK
  };

  // link modes
  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_CONNECTED  = 2'd1;
  localparam logic [1:0] MODE_STREAMING  = 2'd2;
  localparam logic [1:0] MODE_PREDICTING = 2'd3;

  // parser phases
  localparam logic [2:0] PH_KEY   = 3'd0;
  localparam logic [2:0] PH_COLON = 3'd1;
  localparam logic [2:0] PH_SKIP  = 3'd2;
  localparam logic [2:0] PH_WORD  = 3'd3;

  typedef struct packed {
    logic [2:0] command_code;
    logic [1:0] link_mode;
    logic       send_ack;
    logic       start_event;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/serial_command_link_fsm.sv
// serial command link: per-byte line parser and four-state link machine
// depends on scl_pkg
`default_nettype none

// Takes one received byte per clock and updates the line parser and link
// state in that same cycle; a line terminator after a non-empty line
// registers one result item in the result register, or in the one skid
// entry while that register holds an untaken item; in_stall_o rises only
// when both hold items the consumer has not taken; with the output flowing
// the block sustains one byte per cycle. Byte 0xFF is dropped without effect.
module serial_command_link_fsm (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      command_code_o,
  output logic [1:0]      link_mode_o,
  output logic            send_ack_o,
  output logic            start_event_o
);

  logic [1:0]                     mode_q, mode_d;
  logic [scl_pkg::LEN_W-1:0]      len_q, len_d;
  logic                           ended_q, ended_d;
  logic [2:0]                     phase_q, phase_d;
  logic [scl_pkg::KP_W-1:0]       kp_q, kp_d;
  logic [scl_pkg::WPOS_W-1:0]     wpos_q, wpos_d;
  logic [scl_pkg::NUM_WORDS-1:0]  cand_q, cand_d;

  scl_pkg::result_t out_q, out_d, skid_q, skid_d, res;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic             res_valid, accept, out_take, do_word;
  logic [2:0]       cmd;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  // command decoded from the line so far, lowest index wins
  always_comb begin
    cmd = scl_pkg::CODE_NONE;
    if (phase_q == scl_pkg::PH_WORD) begin
      for (int i = scl_pkg::NUM_WORDS - 1; i >= 0; i--) begin
        if (cand_q[i] && wpos_q >= scl_pkg::WORD_LEN[i]) begin
          cmd = scl_pkg::WORD_CODE[i];
        end
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    ended_d   = ended_q;
    phase_d   = phase_q;
    kp_d      = kp_q;
    wpos_d    = wpos_q;
    cand_d    = cand_q;
    do_word   = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (accept && rx_byte_i != scl_pkg::CH_SKIP) begin
      if (rx_byte_i != scl_pkg::CH_LF && rx_byte_i != scl_pkg::CH_CR) begin
        if (len_q < scl_pkg::LEN_W'(scl_pkg::LINE_CAPACITY - 1)) begin
          len_d = len_q + scl_pkg::LEN_W'(1);
          if (!ended_q) begin
            if (rx_byte_i == scl_pkg::CH_NUL) begin
              ended_d = 1'b1;
            end else begin
              unique case (phase_q)
                scl_pkg::PH_KEY: begin
                  if (kp_q < scl_pkg::KP_W'(scl_pkg::KEY_LEN)) begin
                    if (rx_byte_i == scl_pkg::KEY_TEXT[kp_q]) begin
                      if (kp_q == scl_pkg::KP_W'(scl_pkg::KEY_LEN - 1)) begin
                        phase_d = scl_pkg::PH_COLON;
                        kp_d    = '0;
                      end else begin
                        kp_d = kp_q + scl_pkg::KP_W'(1);
                      end
                    end else begin
                      kp_d = (rx_byte_i == scl_pkg::CH_QUOTE) ? scl_pkg::KP_W'(1) : '0;
                    end
                  end else begin
                    kp_d = (rx_byte_i == scl_pkg::CH_QUOTE) ? scl_pkg::KP_W'(1) : '0;
                  end
                end
                scl_pkg::PH_COLON: begin
                  if (rx_byte_i == scl_pkg::CH_COLON) begin
                    phase_d = scl_pkg::PH_SKIP;
                  end
                end
                scl_pkg::PH_SKIP: begin
                  if (rx_byte_i != scl_pkg::CH_SPACE && rx_byte_i != scl_pkg::CH_QUOTE) begin
                    phase_d = scl_pkg::PH_WORD;
                    do_word = 1'b1;
                  end
                end
                scl_pkg::PH_WORD: begin
                  do_word = 1'b1;
                end
                default: begin
                end
              endcase

              if (do_word && wpos_q < scl_pkg::WPOS_W'(scl_pkg::LONGEST_WORD)) begin
                for (int i = 0; i < scl_pkg::NUM_WORDS; i++) begin
                  if (cand_q[i] && wpos_q < scl_pkg::WORD_LEN[i]) begin
                    if (rx_byte_i != scl_pkg::WORD_TEXT[i][wpos_q]) begin
                      cand_d[i] = 1'b0;
                    end
                  end
                end
                wpos_d = wpos_q + scl_pkg::WPOS_W'(1);
              end
            end
          end
        end else begin
          // overflowing byte dropped, line restarts
          len_d   = '0;
          ended_d = 1'b0;
          phase_d = scl_pkg::PH_KEY;
          kp_d    = '0;
          wpos_d  = '0;
          cand_d  = '1;
        end
      end else if (len_q != '0) begin
        res_valid        = 1'b1;
        res.command_code = cmd;
        if (cmd == scl_pkg::CODE_LINK) begin
          mode_d       = scl_pkg::MODE_CONNECTED;
          res.send_ack = 1'b1;
        end else if (cmd != scl_pkg::CODE_NONE) begin
          unique case (mode_q)
            scl_pkg::MODE_CONNECTED: begin
              if (cmd == scl_pkg::CODE_STREAM) begin
                mode_d          = scl_pkg::MODE_STREAMING;
                res.start_event = 1'b1;
              end else if (cmd == scl_pkg::CODE_INFER) begin
                mode_d          = scl_pkg::MODE_PREDICTING;
                res.start_event = 1'b1;
              end else if (cmd == scl_pkg::CODE_UNLINK) begin
                mode_d = scl_pkg::MODE_IDLE;
              end
            end
            scl_pkg::MODE_STREAMING, scl_pkg::MODE_PREDICTING: begin
              if (cmd == scl_pkg::CODE_HALT) begin
                mode_d = scl_pkg::MODE_CONNECTED;
              end else if (cmd == scl_pkg::CODE_UNLINK) begin
                mode_d = scl_pkg::MODE_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        res.link_mode = mode_d;
        len_d   = '0;
        ended_d = 1'b0;
        phase_d = scl_pkg::PH_KEY;
        kp_d    = '0;
        wpos_d  = '0;
        cand_d  = '1;
      end
    end
  end

  // result register with one skid entry
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_d        = skid_q;
      out_valid_d  = skid_valid_q;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= scl_pkg::MODE_IDLE;
      len_q        <= '0;
      ended_q      <= 1'b0;
      phase_q      <= scl_pkg::PH_KEY;
      kp_q         <= '0;
      wpos_q       <= '0;
      cand_q       <= '1;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      len_q        <= len_d;
      ended_q      <= ended_d;
      phase_q      <= phase_d;
      kp_q         <= kp_d;
      wpos_q       <= wpos_d;
      cand_q       <= cand_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign command_code_o = out_q.command_code;
  assign link_mode_o    = out_q.link_mode;
  assign send_ack_o     = out_q.send_ack;
  assign start_event_o  = out_q.start_event;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_ack_means_connect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_ack_o) |->
      (command_code_o == scl_pkg::CODE_LINK && link_mode_o == scl_pkg::MODE_CONNECTED))
    else $error("acknowledge without connect");

  a_event_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_event_o) |->
      (link_mode_o == scl_pkg::MODE_STREAMING || link_mode_o == scl_pkg::MODE_PREDICTING))
    else $error("start event outside streaming or predicting");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= scl_pkg::LEN_W'(scl_pkg::LINE_CAPACITY - 1))
    else $error("line length beyond capacity");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// testbench for serial_command_link_fsm: directed command lines, then random lines
// checked against a local line parser and link mode tracker; depends on scl_pkg
`timescale 1ns / 100ps

module tb;
  import scl_pkg::*;

  typedef struct {
    int      pad;
    string   text;
    bit      pinned;
    result_t want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] command_code;
  logic [1:0] link_mode;
  logic       send_ack;
  logic       start_event;

  bit         calm = 1'b0;
  int         mismatches = 0;
  int         items_sent = 0;

  // line parser and link mode tracker
  logic [1:0] mode_now = MODE_IDLE;
  int         line_len;
  bit         zero_seen;
  logic [2:0] phase;
  int         key_cnt;
  int         word_idx;
  logic [4:0] word_live;

  string      key_str = "\"cmd\"";
  string      cmd_words[NUM_WORDS] = '{"connect", "start_predict", "start", "stop", "disconnect"};
  logic [2:0] cmd_codes[NUM_WORDS] = '{CODE_LINK, CODE_INFER, CODE_STREAM, CODE_HALT,
                                      CODE_UNLINK};

  result_t    link_reports[$];
  result_t    pinned_reports[$];
  logic [7:0] tx_bytes[$];

  // '#' stands for a zero byte and '@' for 0xff
  row_t dir_rows[22] = '{
    '{0, "\n", 1'b0, '0},
    '{0, "@\r", 1'b0, '0},
    '{0, "{\"cmd\":\"start\"}\n", 1'b1, '{CODE_STREAM, MODE_IDLE, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"connect\"}\r", 1'b1, '{CODE_LINK, MODE_CONNECTED, 1'b1, 1'b0}},
    '{0, "{\"cmd\": \"start\"}\n", 1'b1, '{CODE_STREAM, MODE_STREAMING, 1'b0, 1'b1}},
    '{0, "{\"cmd\":\"start_predict\"}\n", 1'b1,
      '{CODE_INFER, MODE_STREAMING, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"stop\"}\n", 1'b1, '{CODE_HALT, MODE_CONNECTED, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"start_predict\"}\n", 1'b1,
      '{CODE_INFER, MODE_PREDICTING, 1'b0, 1'b1}},
    '{0, "{\"cmd\":\"connect\"}\n", 1'b1, '{CODE_LINK, MODE_CONNECTED, 1'b1, 1'b0}},
    '{0, "{\"cmd\":\"disconnect\"}\n", 1'b1, '{CODE_UNLINK, MODE_IDLE, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"stop\"}\n", 1'b1, '{CODE_HALT, MODE_IDLE, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"disconnect\"}\n", 1'b1, '{CODE_UNLINK, MODE_IDLE, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"sta#rt\"}\n", 1'b0, '0},
    '{0, "{\"cmd\":\"stop#\"}\n", 1'b0, '0},
    '{0, "hello\n", 1'b1, '{CODE_NONE, MODE_IDLE, 1'b0, 1'b0}},
    '{0, "#\n", 1'b1, '{CODE_NONE, MODE_IDLE, 1'b0, 1'b0}},
    '{0, "{\"cmd\":\"connectxyz\"}\r\n", 1'b0, '0},
    '{0, "\"\"cmd\" :  \"start_predictzz\"\n", 1'b0, '0},
    '{0, "{\"cmd\":\"star\"}\n", 1'b0, '0},
    '{115, "\"cmd\":\"stop\"\n", 1'b0, '0},
    '{127, "\"cmd\":\"connect\"\n", 1'b0, '0},
    '{0, "\"cmd\"\n", 1'b0, '0}
  };

  serial_command_link_fsm i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .command_code_o (command_code),
    .link_mode_o    (link_mode),
    .send_ack_o     (send_ack),
    .start_event_o  (start_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_line();
    line_len  = 0;
    zero_seen = 1'b0;
    phase     = PH_KEY;
    key_cnt   = 0;
    word_idx  = 0;
    word_live = 5'h1f;
  endfunction

  task automatic track_link_byte(input logic [7:0] b);
    result_t r;
    if (b == CH_SKIP) return;
    if (b != CH_LF && b != CH_CR) begin
      if (line_len >= LINE_CAPACITY - 1) begin
        clear_line();
        return;
      end
      line_len++;
      if (zero_seen) return;
      if (b == CH_NUL) begin
        zero_seen = 1'b1;
        return;
      end
      case (phase)
        PH_KEY: begin
          if (key_cnt < KEY_LEN && b == key_str[key_cnt]) begin
            key_cnt++;
            if (key_cnt == KEY_LEN) begin
              phase   = PH_COLON;
              key_cnt = 0;
            end
          end else begin
            key_cnt = (b == CH_QUOTE) ? 1 : 0;
          end
        end
        PH_COLON: if (b == CH_COLON) phase = PH_SKIP;
        PH_SKIP, PH_WORD: begin
          if (phase == PH_WORD || (b != CH_SPACE && b != CH_QUOTE)) begin
            phase = PH_WORD;
            if (word_idx < LONGEST_WORD) begin
              for (int k = 0; k < NUM_WORDS; k++) begin
                if (word_live[k] && word_idx < cmd_words[k].len() &&
                    b != cmd_words[k][word_idx]) word_live[k] = 1'b0;
              end
              word_idx++;
            end
          end
        end
        default: ;
      endcase
      return;
    end
    if (line_len == 0) return;

    r = '0;
    if (phase == PH_WORD) begin
      for (int k = NUM_WORDS - 1; k >= 0; k--) begin
        if (word_live[k] && word_idx >= cmd_words[k].len()) r.command_code = cmd_codes[k];
      end
    end
    if (r.command_code == CODE_LINK) begin
      mode_now   = MODE_CONNECTED;
      r.send_ack = 1'b1;
    end else if (r.command_code != CODE_NONE) begin
      case (mode_now)
        MODE_CONNECTED: begin
          if (r.command_code == CODE_STREAM) begin
            mode_now      = MODE_STREAMING;
            r.start_event = 1'b1;
          end else if (r.command_code == CODE_INFER) begin
            mode_now      = MODE_PREDICTING;
            r.start_event = 1'b1;
          end else if (r.command_code == CODE_UNLINK) begin
            mode_now = MODE_IDLE;
          end
        end
        MODE_STREAMING, MODE_PREDICTING: begin
          if (r.command_code == CODE_HALT) mode_now = MODE_CONNECTED;
          else if (r.command_code == CODE_UNLINK) mode_now = MODE_IDLE;
        end
        default: ;
      endcase
    end
    r.link_mode = mode_now;
    clear_line();
    link_reports.push_back(pinned_reports.size() != 0 ? pinned_reports.pop_front() : r);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        items_sent++;
        track_link_byte(rx_byte);
      end
      if (out_valid && !out_stall) begin
        if (link_reports.size() == 0) begin
          flag_mismatch($sformatf("unexpected item cmd %0d mode %0d", command_code, link_mode));
        end else begin
          want = link_reports.pop_front();
          if (command_code !== want.command_code)
            flag_mismatch($sformatf("command_code expected %0d got %0d",
                                    want.command_code, command_code));
          if (link_mode !== want.link_mode)
            flag_mismatch($sformatf("link_mode expected %0d got %0d",
                                    want.link_mode, link_mode));
          if (send_ack !== want.send_ack)
            flag_mismatch($sformatf("send_ack expected %0b got %0b", want.send_ack, send_ack));
          if (start_event !== want.start_event)
            flag_mismatch($sformatf("start_event expected %0b got %0b",
                                    want.start_event, start_event));
        end
      end
    end
  end

  always @(negedge clk) out_stall <= !calm && $urandom_range(99) < 18;

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    while (tx_bytes.size() != 0) begin
      if ($urandom_range(99) < 3) send_byte(CH_SKIP);
      send_byte(tx_bytes.pop_front());
    end
  endtask

  function automatic void add_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      if (s[k] == "#") tx_bytes.push_back(CH_NUL);
      else if (s[k] == "@") tx_bytes.push_back(CH_SKIP);
      else tx_bytes.push_back(s[k]);
    end
  endfunction

  function automatic logic [7:0] line_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
    return b;
  endfunction

  initial begin
    int    line_no;
    int    cut;
    int    wait_cnt;
    int    n_chars;
    string w;
    clear_line();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].pinned) pinned_reports.push_back(dir_rows[r].want);
      repeat (dir_rows[r].pad) tx_bytes.push_back("x");
      add_text(dir_rows[r].text);
      send_text();
    end

    cut = 950;
    line_no = 0;
    while (items_sent < cut) begin
      calm = (line_no >= 4 && line_no < 12);
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 24)) tx_bytes.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) tx_bytes.push_back(line_noise());
        if ($urandom_range(1)) add_text("{\"cmd\"");
        else add_text("\"cmd\"");
        repeat ($urandom_range(2)) tx_bytes.push_back(CH_SPACE);
        if ($urandom_range(9) != 0) tx_bytes.push_back(CH_COLON);
        repeat ($urandom_range(3)) tx_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_QUOTE);
        w = cmd_words[$urandom_range(NUM_WORDS - 1)];
        n_chars = ($urandom_range(9) == 0) ? int'($urandom_range(w.len() - 1)) : w.len();
        for (int k = 0; k < n_chars; k++) tx_bytes.push_back(w[k]);
        case ($urandom_range(9))
          0: tx_bytes.push_back(CH_NUL);
          1: add_text("zz");
          2: tx_bytes.push_back(CH_SKIP);
          default: ;
        endcase
        add_text("\"}");
        if ($urandom_range(19) == 0)
          repeat ($urandom_range(100, 140)) tx_bytes.push_back(line_noise());
      end
      case ($urandom_range(3))
        0: tx_bytes.push_back(CH_LF);
        1: tx_bytes.push_back(CH_CR);
        2: begin
          tx_bytes.push_back(CH_CR);
          tx_bytes.push_back(CH_LF);
        end
        default: begin
          tx_bytes.push_back(CH_LF);
          tx_bytes.push_back(CH_LF);
        end
      endcase
      send_text();
      line_no++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (link_reports.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (link_reports.size() != 0)
      flag_mismatch($sformatf("%0d expected items never arrived", link_reports.size()));

    if (mismatches == 0) begin
      $display("PASS serial_command_link_fsm");
    end else begin
      $display("FAIL serial_command_link_fsm");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL serial_command_link_fsm");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/scl_pkg.sv
rtl/core/serial_command_link_fsm.sv
tb/sv/tb.sv
